### rtl/hjb_pkg.sv
// shared types, request codes and configuration helpers for the hash join block
`timescale 1ns / 1ps

package hjb_pkg;

  localparam int SIZE_W  = 13;
  localparam int KEY_W   = 32;
  localparam int REQ_W   = 2;
  localparam int TOTAL_W = 48;

  localparam logic [REQ_W-1:0] REQ_START = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BUILD = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PROBE = 2'd2;

  localparam logic [SIZE_W-1:0]  PROBE_MAX    = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX    = '1;
  localparam logic [SIZE_W-1:0]  SIZE_AT_RST  = 13'd4096;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [KEY_W-1:0] key;
  } hjb_in_t;

  typedef struct packed {
    logic               status;
    logic [SIZE_W-1:0]  probe_matches;
    logic [TOTAL_W-1:0] total_matches;
  } hjb_out_t;

  // effective table size and bucket index mask derived from build_size
  typedef struct packed {
    logic [SIZE_W-1:0] eff;
    logic [SIZE_W-1:0] mask;
  } hjb_cfg_t;

  function automatic hjb_cfg_t cfg_from_size(logic [SIZE_W-1:0] size, int unsigned max_build);
    hjb_cfg_t          c;
    logic [SIZE_W-1:0] m;
    if (32'(size) > max_build) begin
      c.eff = SIZE_W'(max_build);
    end else begin
      c.eff = size;
    end
    // next power of two minus one: smear the top bit of eff-1 downward
    m = c.eff - SIZE_W'(1);
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    c.mask = (c.eff <= SIZE_W'(1)) ? '0 : m;
    return c;
  endfunction

endpackage

### rtl/hash_join_bucket_chain.sv
// bucket chaining hash join: config register, request engine and output register
// a probe walks every entry of its bucket chain; a start request sweeps the bucket heads
// throughput: one request in flight; the chain walk reads one entry memory word per cycle
// reset: synchronous; afterwards a sweep over all 2^ceil(log2(MAX_BUILD)) bucket heads empties
//   them before the first request is taken; build_size resets to 4096
`timescale 1ns / 1ps

module hash_join_bucket_chain #(
  parameter int MAX_BUILD   = 4096,
  parameter int RADIX_SHIFT = 14
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  hjb_pkg::hjb_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output hjb_pkg::hjb_out_t           out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hjb_pkg::SIZE_W-1:0]  cfg_data
);
  import hjb_pkg::*;

  hjb_cfg_t cfg_r;
  logic     idle;
  logic     res_valid;
  hjb_out_t res_data;
  logic     res_take;
  logic     out_valid_r;
  hjb_out_t out_data_r;

  assign cfg_ready = idle;
  assign in_stall  = !idle;
  // output register frees when empty or drained this cycle
  assign res_take  = res_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res_data;
    end
    if (!rst_n) begin
      cfg_r       <= cfg_from_size(SIZE_AT_RST, MAX_BUILD);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_from_size(cfg_data, MAX_BUILD);
      end
      if (res_take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  hjb_engine #(
    .MAX_BUILD   (MAX_BUILD),
    .RADIX_SHIFT (RADIX_SHIFT)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .idle      (idle),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_take  (res_take)
  );

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or dropped");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |-> !in_stall)
    else $error("config write taken while busy");

  a_take_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |-> (!out_valid_r || !out_stall))
    else $error("result taken into a full output register");
`endif

endmodule

### rtl/hjb_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module hjb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/hjb_engine.sv
// request sequencer: bucket head and entry memories, clear sweep, build and chain walk
`timescale 1ns / 1ps

module hjb_engine #(
  parameter int MAX_BUILD   = 4096,
  parameter int RADIX_SHIFT = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  hjb_pkg::hjb_cfg_t cfg,
  input  logic             in_valid,
  input  hjb_pkg::hjb_in_t in_data,
  output logic             idle,
  output logic             res_valid,
  output hjb_pkg::hjb_out_t res_data,
  input  logic             res_take
);
  import hjb_pkg::*;

  localparam int POS_W = $clog2(MAX_BUILD + 1);
  localparam int IDX_W = $clog2(MAX_BUILD);
  localparam int HD    = 1 << IDX_W;
  localparam int ENT_W = POS_W + KEY_W;
  localparam int CMP_W = (POS_W > SIZE_W) ? POS_W : SIZE_W;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_B_RD, S_B_WR, S_P_RD, S_P_POS, S_P_ENT, S_ACC, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic               clr_reply_r, clr_reply_nxt;
  logic [POS_W-1:0]   build_count_r, build_count_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [POS_W-1:0]   cnt_r, cnt_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  hjb_out_t           res_r, res_nxt;

  logic               head_we;
  logic [IDX_W-1:0]   head_waddr;
  logic [POS_W-1:0]   head_wdata;
  logic [POS_W-1:0]   head_rdata;
  logic               ent_we;
  logic [ENT_W-1:0]   ent_wdata;
  logic [IDX_W-1:0]   ent_raddr;
  logic [ENT_W-1:0]   ent_rdata;
  logic [POS_W-1:0]   ent_next;
  logic [KEY_W-1:0]   ent_key;
  logic [POS_W-1:0]   pos;
  logic [IDX_W-1:0]   bucket;
  logic [KEY_W-1:0]   shifted;
  logic [KEY_W-1:0]   mask_ext;
  logic               full;
  logic [CMP_W-1:0]   cnt_ext;
  logic [TOTAL_W:0]   sum;

  assign shifted  = key_r >> RADIX_SHIFT;
  assign mask_ext = KEY_W'(cfg.mask);
  assign bucket   = shifted[IDX_W-1:0] & mask_ext[IDX_W-1:0];
  assign full     = CMP_W'(build_count_r) >= CMP_W'(cfg.eff);

  assign ent_next = ent_rdata[ENT_W-1:KEY_W];
  assign ent_key  = ent_rdata[KEY_W-1:0];
  // walk position comes from the head on the first hop, then from the entry link
  assign pos       = (state_r == S_P_POS) ? head_rdata : ent_next;
  assign ent_raddr = IDX_W'(pos - POS_W'(1));

  assign cnt_ext = CMP_W'(cnt_r);
  assign sum     = {1'b0, total_r} + (TOTAL_W + 1)'(cnt_r);

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res_data  = res_r;

  always_comb begin
    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    clr_reply_nxt   = clr_reply_r;
    build_count_nxt = build_count_r;
    total_nxt       = total_r;
    cnt_nxt         = cnt_r;
    key_nxt         = key_r;
    res_nxt         = res_r;
    head_we         = 1'b0;
    head_waddr      = bucket;
    head_wdata      = build_count_r + POS_W'(1);
    ent_we          = 1'b0;
    ent_wdata       = {head_rdata, key_r};

    unique case (state_r)
      S_CLR: begin
        head_we      = 1'b1;
        head_waddr   = clr_addr_r;
        head_wdata   = '0;
        clr_addr_nxt = clr_addr_r + IDX_W'(1);
        if (clr_addr_r == IDX_W'(HD - 1)) begin
          res_nxt   = '0;
          state_nxt = clr_reply_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          key_nxt = in_data.key;
          cnt_nxt = '0;
          if (in_data.req_type == REQ_START) begin
            clr_addr_nxt    = '0;
            clr_reply_nxt   = 1'b1;
            build_count_nxt = '0;
            total_nxt       = '0;
            state_nxt       = S_CLR;
          end else if (in_data.req_type == REQ_BUILD) begin
            if (full) begin
              res_nxt   = '{status: 1'b1, probe_matches: '0, total_matches: total_r};
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_B_RD;
            end
          end else if (in_data.req_type == REQ_PROBE) begin
            state_nxt = S_P_RD;
          end else begin
            res_nxt   = '{status: 1'b0, probe_matches: '0, total_matches: total_r};
            state_nxt = S_DONE;
          end
        end
      end
      S_B_RD: begin
        state_nxt = S_B_WR;
      end
      S_B_WR: begin
        // new entry points at the old head and becomes the head
        head_we         = 1'b1;
        ent_we          = 1'b1;
        build_count_nxt = build_count_r + POS_W'(1);
        res_nxt         = '{status: 1'b0, probe_matches: '0, total_matches: total_r};
        state_nxt       = S_DONE;
      end
      S_P_RD: begin
        state_nxt = S_P_POS;
      end
      S_P_POS: begin
        state_nxt = (pos == '0) ? S_ACC : S_P_ENT;
      end
      S_P_ENT: begin
        if (ent_key == key_r) begin
          cnt_nxt = cnt_r + POS_W'(1);
        end
        state_nxt = (pos == '0) ? S_ACC : S_P_ENT;
      end
      S_ACC: begin
        total_nxt = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
        res_nxt.status        = 1'b0;
        res_nxt.probe_matches = (cnt_ext > CMP_W'(PROBE_MAX)) ? PROBE_MAX
                                                              : cnt_ext[SIZE_W-1:0];
        res_nxt.total_matches = total_nxt;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
    if (!rst_n) begin
      // heads are swept to empty after reset, with no result
      state_r       <= S_CLR;
      clr_addr_r    <= '0;
      clr_reply_r   <= 1'b0;
      build_count_r <= '0;
      total_r       <= '0;
    end else begin
      state_r       <= state_nxt;
      clr_addr_r    <= clr_addr_nxt;
      clr_reply_r   <= clr_reply_nxt;
      build_count_r <= build_count_nxt;
      total_r       <= total_nxt;
    end
  end

  hjb_ram #(
    .WIDTH (POS_W),
    .DEPTH (HD)
  ) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (bucket),
    .rdata (head_rdata)
  );

  hjb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (HD)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (build_count_r[IDX_W-1:0]),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && state_r == S_IDLE) |=> state_r != S_IDLE)
    else $error("accepted request did not leave idle");

  a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P_POS) |-> head_rdata <= build_count_r)
    else $error("bucket head points past stored entries");

  a_link_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P_ENT) |-> ent_next <= build_count_r)
    else $error("chain link points past stored entries");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    build_count_r <= POS_W'(MAX_BUILD))
    else $error("build count exceeds table capacity");
`endif

endmodule

### tb/hash_join_bucket_chain_test.sv
// self-checking testbench for the bucket chaining hash join block
`timescale 1ns / 1ps

module hash_join_bucket_chain_test;
  import hjb_pkg::*;

  localparam int MAX_BUILD      = 4096;
  localparam int RADIX_SHIFT    = 14;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int RANDOM_TARGET  = 1140;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  hjb_in_t          in_data;
  logic             out_valid;
  logic             out_stall;
  hjb_out_t         out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [SIZE_W-1:0] cfg_data;

  hash_join_bucket_chain #(
    .MAX_BUILD  (MAX_BUILD),
    .RADIX_SHIFT(RADIX_SHIFT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // join table mirror
  logic [SIZE_W-1:0]  head_tbl [MAX_BUILD];
  logic [SIZE_W-1:0]  link_tbl [MAX_BUILD];
  logic [KEY_W-1:0]   key_tbl  [MAX_BUILD];
  int unsigned        n_built;
  logic [TOTAL_W-1:0] run_total;
  logic [SIZE_W-1:0]  size_reg;

  hjb_out_t    pending_results [$];
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned quiet_cycles;
  bit          in_idle_on;
  bit          out_idle_on;
  bit          long_hold;

  function automatic int unsigned table_cap();
    return (size_reg > MAX_BUILD) ? MAX_BUILD : size_reg;
  endfunction

  function automatic int unsigned bucket_index(logic [KEY_W-1:0] k);
    int unsigned nb;
    nb = 1;
    while (nb < table_cap()) nb = nb << 1;
    return (k >> RADIX_SHIFT) & (nb - 1);
  endfunction

  function automatic void clear_join();
    for (int i = 0; i < MAX_BUILD; i++) head_tbl[i] = '0;
    n_built   = 0;
    run_total = '0;
  endfunction

  function automatic hjb_out_t join_predict(hjb_in_t rq);
    hjb_out_t    r;
    int unsigned slot;
    int unsigned pos;
    int unsigned steps;
    int unsigned cnt;
    r     = '0;
    steps = 0;
    cnt   = 0;
    case (rq.req_type)
      REQ_START: clear_join();
      REQ_BUILD: begin
        if (n_built >= table_cap() || n_built >= MAX_BUILD) begin
          r.status = 1'b1;
        end else begin
          slot              = bucket_index(rq.key);
          key_tbl[n_built]  = rq.key;
          link_tbl[n_built] = head_tbl[slot];
          n_built++;
          head_tbl[slot]    = SIZE_W'(n_built);
        end
      end
      REQ_PROBE: begin
        slot = bucket_index(rq.key);
        pos  = head_tbl[slot];
        while (pos != 0 && pos <= MAX_BUILD && steps < MAX_BUILD) begin
          if (key_tbl[pos-1] == rq.key) cnt++;
          pos = link_tbl[pos-1];
          steps++;
        end
        if (TOTAL_W'(cnt) > TOTAL_MAX - run_total) begin
          run_total = TOTAL_MAX;
        end else begin
          run_total = run_total + TOTAL_W'(cnt);
        end
        r.probe_matches = (cnt > PROBE_MAX) ? PROBE_MAX : SIZE_W'(cnt);
      end
      default: ;
    endcase
    r.total_matches = run_total;
    return r;
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [KEY_W-1:0] k);
    hjb_in_t rq;
    rq.req_type = kind;
    rq.key      = k;
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(join_predict(rq));
    items_sent++;
  endtask

  // stop offering requests and wait for every result
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    size_reg = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_basic_ops();
    send_request(REQ_PROBE, 32'h0000_0000);
    send_request(REQ_START, 32'hFFFF_FFFF);
    send_request(REQ_BUILD, 32'h0000_0000);
    send_request(REQ_BUILD, 32'hFFFF_FFFF);
    send_request(REQ_BUILD, 32'h0000_0000);
    send_request(REQ_PROBE, 32'h0000_0000);
    send_request(REQ_PROBE, 32'hFFFF_FFFF);
    // same bucket as key 0, different key
    send_request(REQ_PROBE, 32'h0000_0001);
    send_request(REQ_UNUSED, 32'hFFFF_FFFF);
    send_request(REQ_PROBE, 32'h0000_4000);
    drain();
  endtask

  task automatic test_table_full();
    write_size(SIZE_W'(2));
    send_request(REQ_START, 32'h0);
    send_request(REQ_BUILD, 32'h1234_5678);
    send_request(REQ_BUILD, 32'h1234_5678);
    send_request(REQ_BUILD, 32'h9ABC_DEF0);
    send_request(REQ_PROBE, 32'h1234_5678);
    send_request(REQ_PROBE, 32'h9ABC_DEF0);
    drain();
  endtask

  task automatic test_size_limits();
    // zero size takes no builds and hashes into one bucket
    write_size(SIZE_W'(0));
    send_request(REQ_START, 32'h0);
    send_request(REQ_BUILD, 32'hDEAD_BEEF);
    send_request(REQ_PROBE, 32'hDEAD_BEEF);
    drain();
    // sizes past the table depth clip to it
    write_size(SIZE_W'(8191));
    send_request(REQ_START, 32'h0);
    send_request(REQ_BUILD, 32'hFFFF_C000);
    send_request(REQ_PROBE, 32'hFFFF_C000);
    drain();
  endtask

  task automatic test_resize_mid_join();
    write_size(SIZE_W'(4096));
    send_request(REQ_START, 32'h0);
    send_request(REQ_BUILD, 32'h0000_4000);
    send_request(REQ_BUILD, 32'h0000_8000);
    send_request(REQ_BUILD, 32'h0000_0005);
    drain();
    // one bucket now: chains outside bucket 0 drop out of reach and the table counts as full
    write_size(SIZE_W'(1));
    send_request(REQ_PROBE, 32'h0000_4000);
    send_request(REQ_PROBE, 32'h0000_0005);
    send_request(REQ_BUILD, 32'h0000_0007);
    drain();
    write_size(SIZE_W'(4096));
    send_request(REQ_PROBE, 32'h0000_4000);
    drain();
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    logic [KEY_W-1:0] k;
    k = $urandom();
    write_size(SIZE_W'(64));
    send_request(REQ_START, 32'h0);
    long_hold = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 2) send_request(REQ_PROBE, k);
      else send_request(REQ_BUILD, (i % 2) ? k : {k[31:14], 14'($urandom())});
    end
    drain();
  endtask

  task automatic run_random_join(input int unsigned n_req, input bit allow_idle);
    logic [KEY_W-1:0] pool [6];
    logic [KEY_W-1:0] k;
    int unsigned      pick;
    drain();
    in_idle_on  = allow_idle && ($urandom_range(0, 9) < 7);
    out_idle_on = allow_idle && ($urandom_range(0, 9) < 7);
    case ($urandom_range(0, 9))
      0: write_size(SIZE_W'(1));
      1: write_size(SIZE_W'(2));
      2: write_size(SIZE_W'($urandom_range(3, 16)));
      3: write_size(SIZE_W'($urandom_range(17, 200)));
      4: write_size(SIZE_W'($urandom_range(201, 4095)));
      5: write_size(SIZE_W'(4096));
      6: write_size(SIZE_W'($urandom_range(4097, 8191)));
      7: write_size(SIZE_W'(8191));
      8: write_size(SIZE_W'(0));
      default: ;
    endcase
    pool[0] = $urandom();
    for (int i = 1; i < 6; i++) begin
      case ($urandom_range(0, 2))
        0: pool[i] = $urandom();
        1: pool[i] = {pool[0][31:14], 14'($urandom())};
        default: pool[i] = pool[$urandom_range(0, i - 1)];
      endcase
    end
    send_request(REQ_START, $urandom());
    repeat (n_req) begin
      pick = $urandom_range(0, 99);
      k    = pool[$urandom_range(0, 5)];
      if (pick < 35) send_request(REQ_BUILD, k);
      else if (pick < 45) send_request(REQ_BUILD, $urandom());
      else if (pick < 85) send_request(REQ_PROBE, k);
      else if (pick < 92) send_request(REQ_PROBE, $urandom());
      else if (pick < 96) send_request(REQ_PROBE, {k[31:14], 14'($urandom())});
      else if (pick < 99) send_request(REQ_UNUSED, $urandom());
      else send_request(REQ_START, $urandom());
    end
  endtask

  task automatic test_random_joins();
    while (items_sent < RANDOM_TARGET) run_random_join($urandom_range(10, 60), 1'b1);
  endtask

  task automatic test_quiet_tail();
    run_random_join(60, 1'b0);
    drain();
  endtask

  // result stall: random bursts, or one long hold on request
  initial begin : out_stall_gen
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    hjb_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_data.status);
          fail_count++;
        end
        if (out_data.probe_matches !== want.probe_matches) begin
          $display("%0t: probe_matches expected %0d actual %0d", $time,
                   want.probe_matches, out_data.probe_matches);
          fail_count++;
        end
        if (out_data.total_matches !== want.total_matches) begin
          $display("%0t: total_matches expected %0d actual %0d", $time,
                   want.total_matches, out_data.total_matches);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    fail_count   = 0;
    items_sent   = 0;
    quiet_cycles = 0;
    in_idle_on   = 1'b1;
    out_idle_on  = 1'b1;
    long_hold    = 1'b0;
    size_reg     = SIZE_AT_RST;
    for (int i = 0; i < MAX_BUILD; i++) begin
      link_tbl[i] = '0;
      key_tbl[i]  = '0;
    end
    clear_join();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_table_full();
    test_size_limits();
    test_resize_mid_join();
    test_output_backpressure();
    test_random_joins();
    test_quiet_tail();

    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
rtl/hjb_pkg.sv
rtl/hjb_ram.sv
rtl/hjb_engine.sv
rtl/hash_join_bucket_chain.sv
tb/hash_join_bucket_chain_test.sv
